/* design/bsws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_pkg: shared constants for the binary slicer with windowed SNR
// Sample format, window geometry and divider widths.
// ----------------------------------------------------------------------------
package bsws_pkg;

    localparam int WINDOW      = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 4;

    // Squared error: |e| < 2^(SAMPLE_BITS-1), so its square fits 2*SAMPLE_BITS-2 bits.
    localparam int EABS_W = SAMPLE_BITS - 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS - 2;

    localparam int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SQ_W + PTR_W;

    // SNR in Q16.16 of a ratio whose divisor carries 2*FRAC_BITS fraction bits.
    localparam int SNR_SHIFT = 2 * FRAC_BITS + 16;
    localparam int SNR_W     = 32;
    localparam int QUO_W     = (CNT_W + SNR_SHIFT > SNR_W + 1) ?
                               (CNT_W + SNR_SHIFT) : (SNR_W + 1);
    localparam int STEP_W    = $clog2(QUO_W);

    localparam logic [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(1) << FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [SNR_W-1:0]       t_snr;

endpackage

/* design/bsws_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_in_if: soft sample channel
// Valid/ready handshake carrying one signed soft sample per item.
// ----------------------------------------------------------------------------
interface bsws_in_if;
    import bsws_pkg::*;

    logic    valid;
    logic    ready;
    t_sample soft_sample;

    modport source (output valid, output soft_sample, input ready);
    modport sink   (input valid, input soft_sample, output ready);
endinterface

/* design/bsws_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_out_if: decision and SNR channel
// Valid/ready handshake carrying hard bit, SNR estimate and saturation flag.
// ----------------------------------------------------------------------------
interface bsws_out_if;
    import bsws_pkg::*;

    logic valid;
    logic ready;
    logic hard_bit;
    t_snr snr_estimate;
    logic snr_saturated;

    modport source (output valid, output hard_bit, output snr_estimate,
                    output snr_saturated, input ready);
    modport sink   (input valid, input hard_bit, input snr_estimate,
                    input snr_saturated, output ready);
endinterface

/* design/binary_slicer_windowed_snr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_slicer_windowed_snr: hard slicer with sliding-window SNR estimate
// Slices each soft sample to a bit, keeps the last WINDOW squared slicing
// errors in a ring memory with a running sum, and divides the fill count
// by that sum to give an unsigned Q16.16 SNR.
// ----------------------------------------------------------------------------
//
//  Port    Dir  Payload                                     Handshake
//  ------  ---  ------------------------------------------  -----------
//  i_in    in   soft_sample (16b signed, Q3.12)             valid/ready
//  o_out   out  hard_bit, snr_estimate (Q16.16), snr_sat    valid/ready
//
//  Each item passes through accept, a registered memory read, one
//  read-modify-write of the ring slot and running sum, QUO_W steps of the
//  radix-2 restoring divider, and a hand-off into the output register. A new
//  sample is accepted only once the last is handed off; the divider sets the rate.
//  Reset is synchronous, active low; the ring needs no clearing pass, since
//  a slot counts as zero until the fill count reaches WINDOW.
//  The output register holds a result while o_out stalls; the next item is
//  accepted meanwhile and waits at hand-off only if the register is full.
//
module binary_slicer_windowed_snr (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsws_in_if.sink     i_in,
    bsws_out_if.source  o_out
);
    import bsws_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // waiting for a sample
        S_READ = 5'b00010,  // ring read in flight, square being formed
        S_UPD  = 5'b00100,  // ring write-back, sum and count update
        S_DIV  = 5'b01000,  // one quotient bit per cycle
        S_DONE = 5'b10000   // hand result to the output register
    } t_state;

    t_state r_state, n_state;

    // Ring of squared errors, one read and one write port.
    logic [SQ_W-1:0] r_mem [WINDOW];
    logic [SQ_W-1:0] r_rd_data;

    t_sample           r_sample;
    logic [SQ_W-1:0]   r_sq;
    logic [PTR_W-1:0]  r_pos,   n_pos;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum,   n_sum;

    // Divider: remainder and a shared dividend/quotient shift register.
    logic [SUM_W-1:0]  r_rem,  n_rem;
    logic [QUO_W-1:0]  r_quo,  n_quo;
    logic [STEP_W-1:0] r_step;

    logic              r_out_valid;
    logic              r_hard;
    t_snr              r_snr;
    logic              r_sat;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_full;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SAMPLE_BITS:0]   w_err;
    logic [SAMPLE_BITS:0]   w_err_abs;
    logic [EABS_W-1:0]      w_eabs;
    logic [SQ_W-1:0]        w_sq;
    logic [SQ_W-1:0]        w_old;
    logic [SUM_W:0]         w_trial;
    logic [SUM_W:0]         w_diff;
    logic                   w_ge;
    logic                   w_sat;

    assign i_in.ready          = (r_state == S_IDLE);
    assign w_in_acc            = i_in.valid && i_in.ready;
    assign w_out_free          = !r_out_valid || o_out.ready;
    assign w_full              = (r_count == CNT_W'(WINDOW));

    assign o_out.valid         = r_out_valid;
    assign o_out.hard_bit      = r_hard;
    assign o_out.snr_estimate  = r_snr;
    assign o_out.snr_saturated = r_sat;

    // Slicing error e = 1.0 - |x|, then |e|^2. The most negative sample
    // gives |x| = 8.0, which still fits unsigned in SAMPLE_BITS.
    always_comb begin
        w_mag     = r_sample[SAMPLE_BITS-1] ? (~r_sample + SAMPLE_BITS'(1)) : r_sample;
        w_err     = {1'b0, ONE_Q} - {1'b0, w_mag};
        w_err_abs = w_err[SAMPLE_BITS] ? (~w_err + (SAMPLE_BITS + 1)'(1)) : w_err;
        w_eabs    = w_err_abs[EABS_W-1:0];
        w_sq      = SQ_W'(w_eabs) * SQ_W'(w_eabs);
    end

    // Ring slot leaving the window; slots not yet written read as zero.
    assign w_old   = w_full ? r_rd_data : '0;
    assign n_sum   = r_sum - SUM_W'(w_old) + SUM_W'(r_sq);
    assign n_count = w_full ? r_count : r_count + CNT_W'(1);
    assign n_pos   = (r_pos == PTR_W'(WINDOW - 1)) ? '0 : r_pos + PTR_W'(1);

    // Restoring division step against the running noise sum.
    always_comb begin
        w_trial = {r_rem, r_quo[QUO_W-1]};
        w_ge    = (w_trial >= {1'b0, r_sum});
        w_diff  = w_trial - {1'b0, r_sum};
        n_rem   = w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
        n_quo   = {r_quo[QUO_W-2:0], w_ge};
    end

    // Zero noise sum or a quotient past 32 bits saturates.
    assign w_sat = (r_sum == '0) || (|r_quo[QUO_W-1:SNR_W]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_READ;
            end
            S_READ: n_state = S_UPD;
            S_UPD:  n_state = S_DIV;
            S_DIV: begin
                if (r_step == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Ring memory: registered read issued at accept, write-back in update.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_rd_data <= r_mem[r_pos];
        if (r_state == S_UPD) r_mem[r_pos] <= r_sq;
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_sample <= i_in.soft_sample;
        if (r_state == S_READ) r_sq <= w_sq;
        if (r_state == S_UPD) begin
            r_rem  <= '0;
            r_quo  <= QUO_W'(n_count) << SNR_SHIFT;
            r_step <= STEP_W'(QUO_W - 1);
        end else if (r_state == S_DIV) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_step <= r_step - STEP_W'(1);
        end
        if (r_state == S_DONE && w_out_free) begin
            r_hard <= ~r_sample[SAMPLE_BITS-1];
            r_sat  <= w_sat;
            r_snr  <= w_sat ? '1 : r_quo[SNR_W-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPD) begin
                r_pos   <= n_pos;
                r_count <= n_count;
                r_sum   <= n_sum;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* verif/slicer_snr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slicer_snr_checker: prediction and comparison for the slicer with SNR
// Watches both channels, keeps its own copy of the squared-error history and
// fill count, predicts each decision and SNR, and checks results in order.
// ----------------------------------------------------------------------------
module slicer_snr_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bsws_in_if   i_in_mon,
    bsws_out_if  i_out_mon,
    output int   o_failures,
    output int   o_pending
);
    import bsws_pkg::*;

    typedef struct packed {
        logic hard_bit;
        t_snr snr_estimate;
        logic snr_saturated;
    } t_slicer_result;

    localparam int REPORT_MAX = 10;

    logic [SQ_W-1:0]  sq_hist [WINDOW];
    logic [PTR_W-1:0] hist_wr;
    logic [SUM_W-1:0] noise_acc;
    logic [CNT_W-1:0] fill_cnt;

    t_slicer_result   expected_results[$];
    int               fail_cnt   = 0;
    int               report_cnt = 0;

    // Slice one sample and update the windowed noise estimate.
    task automatic slice_and_estimate(input t_sample s, output t_slicer_result r);
        longint          x;
        longint          e;
        logic [SQ_W-1:0] sq;
        logic [63:0]     quo;
        x  = longint'(s);
        e  = (longint'(1) << FRAC_BITS) - ((x < 0) ? -x : x);
        if (e < 0) begin
            e = -e;
        end
        sq = SQ_W'(e * e);

        // oldest square leaves as the newest enters
        noise_acc        = noise_acc - SUM_W'(sq_hist[hist_wr]) + SUM_W'(sq);
        sq_hist[hist_wr] = sq;
        hist_wr          = (hist_wr == PTR_W'(WINDOW - 1)) ? '0 : hist_wr + 1'b1;
        if (fill_cnt < CNT_W'(WINDOW)) begin
            fill_cnt = fill_cnt + 1'b1;
        end

        r.hard_bit = (x >= 0);
        if (noise_acc == '0) begin
            r.snr_estimate  = '1;
            r.snr_saturated = 1'b1;
        end else begin
            quo = (64'(fill_cnt) << SNR_SHIFT) / 64'(noise_acc);
            if ((quo >> SNR_W) != 0) begin
                r.snr_estimate  = '1;
                r.snr_saturated = 1'b1;
            end else begin
                r.snr_estimate  = quo[SNR_W-1:0];
                r.snr_saturated = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_slicer_result want;
        t_slicer_result got;
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                sq_hist[k] = '0;
            end
            hist_wr   = '0;
            noise_acc = '0;
            fill_cnt  = '0;
            expected_results.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                slice_and_estimate(i_in_mon.soft_sample, want);
                expected_results.push_back(want);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.hard_bit      = i_out_mon.hard_bit;
                got.snr_estimate  = i_out_mon.snr_estimate;
                got.snr_saturated = i_out_mon.snr_saturated;
                if (expected_results.size() == 0) begin
                    fail_cnt++;
                    if (report_cnt < REPORT_MAX) begin
                        report_cnt++;
                        $display("checker: result with nothing expected: bit %0d snr %h sat %0d",
                                 got.hard_bit, got.snr_estimate, got.snr_saturated);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.hard_bit !== want.hard_bit ||
                        got.snr_estimate !== want.snr_estimate ||
                        got.snr_saturated !== want.snr_saturated) begin
                        fail_cnt++;
                        if (report_cnt < REPORT_MAX) begin
                            report_cnt++;
                            $display({"checker: mismatch exp bit %0d snr %h sat %0d,",
                                      " got bit %0d snr %h sat %0d"},
                                     want.hard_bit, want.snr_estimate, want.snr_saturated,
                                     got.hard_bit, got.snr_estimate, got.snr_saturated);
                        end
                    end
                end
            end
        end
        o_failures <= fail_cnt;
        o_pending  <= expected_results.size();
    end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for binary_slicer_windowed_snr
// Drives soft samples through directed corner values and shaped random runs
// under three idling regimes; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import bsws_pkg::*;

    // Each item runs the whole divider; a receiver stalling 55% of the
    // time adds a short geometric tail. STALL_LIMIT quiet cycles in a row mean a hang.
    localparam int STALL_LIMIT = 4000;
    // Drain time after the last expected result, longer than one full item pass.
    localparam int TAIL_CYCLES = 64;
    localparam int UNIT        = 1 << FRAC_BITS;   // 1.0 in Q3.12

    logic i_clk = 1'b0;
    logic i_rst_n;

    int   src_idle_pct = 0;
    int   snk_idle_pct = 0;
    int   stall_cycles = 0;
    int   failures;
    int   pending;

    bsws_in_if  in_ch ();
    bsws_out_if out_ch ();

    binary_slicer_windowed_snr i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    slicer_snr_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: stall at random per cycle, at the current regime's rate.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: cycles with no item moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Offer one sample and hold it until the block takes it. A gap of random
    // length goes in front now and then, so that idle cycles land at every
    // point of the divider's run, not only at the accept.
    task automatic push_sample(input t_sample s);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.soft_sample <= s;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Random sample, weighted toward the region around +/-1.0 where the noise
    // sum stays small and the SNR runs near, or into, saturation.
    function automatic t_sample pick_sample();
        int unsigned sel;
        int          mag;
        t_sample     s;
        sel = $urandom_range(99);
        if (sel < 40) begin
            mag = UNIT + int'($urandom_range(128)) - 64;        // near-ideal
        end else if (sel < 55) begin
            mag = UNIT;                                         // exact decision level
        end else if (sel < 70) begin
            mag = UNIT + int'($urandom_range(2048)) - 1024;     // moderate noise
        end else if (sel < 80) begin
            case ($urandom_range(4))
                0:       mag = 32767;
                1:       mag = 0;
                2:       mag = 1;
                default: mag = 32768;                           // most negative below
            endcase
        end else begin
            return t_sample'($urandom);                         // anything at all
        end
        if (mag == 32768) begin
            s = t_sample'(-32768);
        end else if ($urandom_range(1) != 0) begin
            s = t_sample'(-mag);
        end else begin
            s = t_sample'(mag);
        end
        return s;
    endfunction

    task automatic push_random(input int n);
        repeat (n) begin
            push_sample(pick_sample());
        end
    endtask

    // Corner values, right after reset so the window is still empty:
    //   two exact +/-1.0 give a zero noise sum, then an error of one LSB makes
    //   the ratio overflow, then the full-scale extremes and the zero crossing.
    int directed_samples[17] = '{
        UNIT, -UNIT, UNIT - 1, -(UNIT - 1), 0, -32768, 32767, -1, 1,
        UNIT + 1, -(UNIT + 1), 21845, -21846, UNIT / 2, -(UNIT / 2),
        3 * UNIT, -3 * UNIT
    };

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.soft_sample <= '0;
        i_rst_n           <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Regime 1: sender idles lightly, receiver heavily.
        src_idle_pct = 23;
        snk_idle_pct = 55;
        foreach (directed_samples[k]) begin
            push_sample(t_sample'(directed_samples[k]));
        end
        push_random(300);

        // Regime 2: roles swapped. A run of exact decision levels longer than
        // the window drains the noise sum back to zero at full fill.
        src_idle_pct = 55;
        snk_idle_pct = 23;
        push_random(400);
        repeat (WINDOW + 44) begin
            push_sample(t_sample'(($urandom_range(1) != 0) ? UNIT : -UNIT));
        end
        push_random(100);

        // Regime 3: no idling. A full window of one-LSB errors overflows the
        // ratio with the fill count capped.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        push_random(300);
        repeat (WINDOW + 44) begin
            push_sample(t_sample'(($urandom_range(1) != 0) ? UNIT - 1 : -(UNIT + 1)));
        end
        push_random(300);
        in_ch.valid <= 1'b0;

        // let the checker's count take in the last accepted item
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (failures == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
